[hw/rtl/bce_pkg.sv]
// ----------------------------------------------------------------------------
// bce_pkg
// Shared widths, limits and codes for the betweenness centrality engine.
// ----------------------------------------------------------------------------
package bce_pkg;

   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 8192;
   localparam int FRAC_BITS = 16;

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int NCNT_W  = NODE_W + 1;
   localparam int EDGE_W  = $clog2(MAX_EDGES);
   localparam int ECNT_W  = EDGE_W + 1;
   localparam int RO_DEPTH = MAX_NODES + 1;
   localparam int RO_AW   = $clog2(RO_DEPTH);
   localparam int DIST_W  = NCNT_W;
   localparam int PC_W    = 40;
   localparam int FIX_W   = 48;
   localparam int DIV_W   = PC_W + FRAC_BITS;
   localparam int MULB_W  = FIX_W + 1;

   localparam int MODE_W  = 3;
   localparam int INDEX_W = 13;
   localparam int VALUE_W = 14;
   localparam int SCORE_W = FIX_W;

   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [DIST_W-1:0] DIST_UNREACHED = {DIST_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_WR_OFFSET = 3'd0,
      MODE_WR_EDGE   = 3'd1,
      MODE_RUN       = 3'd2,
      MODE_READ      = 3'd3,
      MODE_CLEAR     = 3'd4
   } mode_type;

   typedef enum logic {
      REG_NODE_COUNT = 1'b0,
      REG_EDGE_COUNT = 1'b1
   } reg_index_type;

endpackage

[hw/rtl/betweenness_centrality_engine_core.sv]
// Load, clear-select and read beats: one beat per cycle for loads while idle; a read
// goes through the centrality RAM read register and the output register. A run beat
// stalls the input for the init sweep over V nodes, the forward pass over each visited
// node and scanned edge, and the backward pass, where each qualifying edge waits on the
// divider and then the multiplier. Clear beat and reset: a sweep of the centrality RAM
// with req_ready low; CSR writes are taken throughout. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
// betweenness_centrality_engine_core
// Brandes betweenness centrality over a CSR graph held in on-chip RAMs.
// One sequencer walks BFS then the reverse visit order, with a shared
// divider and multiplier for dependency accumulation.
// ----------------------------------------------------------------------------
module betweenness_centrality_engine_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bce_pkg::MODE_W-1:0]    req_mode,
   input  logic [bce_pkg::INDEX_W-1:0]   req_index,
   input  logic [bce_pkg::VALUE_W-1:0]   req_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bce_pkg::NODE_W-1:0]    rsp_node,
   output logic [bce_pkg::SCORE_W-1:0]   rsp_score,
   // CSR port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bce_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [bce_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [bce_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import bce_pkg::*;

   localparam logic [MULB_W-1:0] MUL_ONE = MULB_W'(1) << FRAC_BITS;

   typedef enum logic [4:0] {
      ST_CCLR,   // sweep centrality to zero
      ST_IDLE,
      ST_READ,   // score read, waits for output slot
      ST_RCLR,   // per-run init of distance / path count / dependency
      ST_SRC,    // seed the source
      ST_POP,    // next node from visit order (fwd or back)
      ST_POPW,
      ST_RO0,
      ST_RO1,
      ST_EDGE,
      ST_EW,
      ST_FUPD,   // BFS relax
      ST_BCHK,   // backward: successor qualifies?
      ST_BDIV,
      ST_BMUL,
      ST_BEND,
      ST_BCENT
   } state_type;

   // saturating helpers
   function automatic logic [PC_W-1:0] sat_add40(input logic [PC_W-1:0] a,
                                                 input logic [PC_W-1:0] b);
      logic [PC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PC_W] ? {PC_W{1'b1}} : s[PC_W-1:0];
   endfunction

   function automatic logic [FIX_W-1:0] sat_add48(input logic [FIX_W-1:0] a,
                                                  input logic [FIX_W-1:0] b);
      logic [FIX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FIX_W] ? {FIX_W{1'b1}} : s[FIX_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // sequencer registers
   // ---------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [NCNT_W-1:0]  cnt_ff, cnt_in;
   logic [NCNT_W-1:0]  node_count_ff, node_count_in;
   logic [ECNT_W-1:0]  edge_count_ff, edge_count_in;
   logic [NODE_W-1:0]  src_ff, src_in;
   logic [NODE_W-1:0]  v_ff, v_in;
   logic [NODE_W-1:0]  w_ff, w_in;
   logic [DIST_W-1:0]  dv_ff, dv_in;
   logic [PC_W-1:0]    pv_ff, pv_in;
   logic [ECNT_W-1:0]  k_ff, k_in;
   logic [ECNT_W-1:0]  hi_ff, hi_in;
   logic [NCNT_W-1:0]  head_ff, head_in;   // fwd: queue head, back: remaining
   logic [NCNT_W-1:0]  len_ff, len_in;
   logic               back_ff, back_in;
   logic [FIX_W-1:0]   depw_ff, depw_in;
   logic [FIX_W-1:0]   dep_acc_ff, dep_acc_in;
   logic [NODE_W-1:0]  rd_node_ff, rd_node_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;

   // RAM ports
   logic               ro_we;
   logic [RO_AW-1:0]   ro_wa, ro_ra;
   logic [VALUE_W-1:0] ro_wd, ro_rd;
   logic               et_we;
   logic [EDGE_W-1:0]  et_wa, et_ra;
   logic [NODE_W-1:0]  et_wd, et_rd;
   logic               vo_we;
   logic [NODE_W-1:0]  vo_wa, vo_ra, vo_wd, vo_rd;
   logic               di_we;
   logic [NODE_W-1:0]  di_wa, di_ra;
   logic [DIST_W-1:0]  di_wd, di_rd;
   logic               pc_we;
   logic [NODE_W-1:0]  pc_wa, pc_ra;
   logic [PC_W-1:0]    pc_wd, pc_rd;
   logic               dp_we;
   logic [NODE_W-1:0]  dp_wa, dp_ra;
   logic [FIX_W-1:0]   dp_wd, dp_rd;
   logic               ce_we;
   logic [NODE_W-1:0]  ce_wa, ce_ra;
   logic [FIX_W-1:0]   ce_wd, ce_rd;

   // arithmetic units
   logic               div_start, div_done;
   logic [FIX_W-1:0]   div_ratio;
   logic               mul_start, mul_done;
   logic [MULB_W-1:0]  mul_b;
   logic [FIX_W-1:0]   mul_p;

   // derived values
   logic [NCNT_W-1:0]  v_use;
   logic [ECNT_W-1:0]  e_use;
   logic [ECNT_W-1:0]  ro_clamped;
   logic [DIST_W-1:0]  dv1;
   logic               newly;
   logic [DIST_W-1:0]  dw_eff;
   logic               csr_wr;

   // node / edge counts clamp to the RAM sizes
   assign v_use = (node_count_ff > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_ff;
   assign e_use = (edge_count_ff > ECNT_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES) : edge_count_ff;
   // row offsets clamp to E; start >= end gives an empty row
   assign ro_clamped = (ro_rd > e_use) ? e_use : ro_rd;
   assign dv1    = dv_ff + DIST_W'(1);
   assign newly  = (di_rd == DIST_UNREACHED) && (len_ff < NCNT_W'(MAX_NODES));
   assign dw_eff = newly ? dv1 : di_rd;
   assign mul_b  = {1'b0, depw_ff} + MUL_ONE;

   // ---------------------------------------------------------------------
   // CSR: pready tied high, decode on the register-select address bit
   // ---------------------------------------------------------------------
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_EDGE_COUNT) ? CSR_DW'(edge_count_ff)
                                                        : CSR_DW'(node_count_ff);

   always_comb begin
      node_count_in = node_count_ff;
      edge_count_in = edge_count_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_EDGE_COUNT) begin
            edge_count_in = csr_pwdata[ECNT_W-1:0];
         end else begin
            node_count_in = csr_pwdata[NCNT_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      dv_in        = dv_ff;
      pv_in        = pv_ff;
      k_in         = k_ff;
      hi_in        = hi_ff;
      head_in      = head_ff;
      len_in       = len_ff;
      back_in      = back_ff;
      depw_in      = depw_ff;
      dep_acc_in   = dep_acc_ff;
      rd_node_in   = rd_node_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_score_in = rsp_score_ff;

      ro_we = 1'b0; ro_wa = '0; ro_wd = '0; ro_ra = '0;
      et_we = 1'b0; et_wa = '0; et_wd = '0; et_ra = '0;
      vo_we = 1'b0; vo_wa = '0; vo_wd = '0; vo_ra = '0;
      di_we = 1'b0; di_wa = '0; di_wd = '0; di_ra = '0;
      pc_we = 1'b0; pc_wa = '0; pc_wd = '0; pc_ra = '0;
      dp_we = 1'b0; dp_wa = '0; dp_wd = '0; dp_ra = '0;
      ce_we = 1'b0; ce_wa = '0; ce_wd = '0; ce_ra = '0;
      div_start = 1'b0;
      mul_start = 1'b0;

      // output slot frees when the beat is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CCLR: begin
            ce_we = 1'b1;
            ce_wa = cnt_ff[NODE_W-1:0];
            if (cnt_ff == NCNT_W'(MAX_NODES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + NCNT_W'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  MODE_WR_OFFSET: begin
                     if (req_index <= INDEX_W'(MAX_NODES)) begin
                        ro_we = 1'b1;
                        ro_wa = req_index[RO_AW-1:0];
                        ro_wd = req_value;
                     end
                  end
                  MODE_WR_EDGE: begin
                     // targets beyond the node RAM are dropped
                     if (req_value < VALUE_W'(MAX_NODES)) begin
                        et_we = 1'b1;
                        et_wa = req_index[EDGE_W-1:0];
                        et_wd = req_value[NODE_W-1:0];
                     end
                  end
                  MODE_RUN: begin
                     if (req_index < INDEX_W'(v_use)) begin
                        src_in   = req_index[NODE_W-1:0];
                        cnt_in   = '0;
                        state_in = ST_RCLR;
                     end
                  end
                  MODE_READ: begin
                     if (req_index < INDEX_W'(v_use)) begin
                        rd_node_in = req_index[NODE_W-1:0];
                        ce_ra      = req_index[NODE_W-1:0];
                        state_in   = ST_READ;
                     end
                  end
                  MODE_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CCLR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ: begin
            ce_ra = rd_node_ff;   // hold address so read data stays put
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = rd_node_ff;
               rsp_score_in = ce_rd;
               state_in     = ST_IDLE;
            end
         end

         ST_RCLR: begin
            di_we = 1'b1; di_wa = cnt_ff[NODE_W-1:0]; di_wd = DIST_UNREACHED;
            pc_we = 1'b1; pc_wa = cnt_ff[NODE_W-1:0];
            dp_we = 1'b1; dp_wa = cnt_ff[NODE_W-1:0];
            if (cnt_ff == v_use - NCNT_W'(1)) begin
               state_in = ST_SRC;
            end else begin
               cnt_in = cnt_ff + NCNT_W'(1);
            end
         end

         ST_SRC: begin
            di_we = 1'b1; di_wa = src_ff;
            pc_we = 1'b1; pc_wa = src_ff; pc_wd = PC_W'(1);
            vo_we = 1'b1; vo_wa = '0;     vo_wd = src_ff;
            len_in   = NCNT_W'(1);
            head_in  = '0;
            back_in  = 1'b0;
            state_in = ST_POP;
         end

         ST_POP: begin
            if (!back_ff) begin
               if (head_ff == len_ff) begin
                  back_in = 1'b1;
                  head_in = len_ff;
               end else begin
                  vo_ra    = head_ff[NODE_W-1:0];
                  state_in = ST_POPW;
               end
            end else begin
               if (head_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  vo_ra    = head_ff[NODE_W-1:0] - NODE_W'(1);
                  state_in = ST_POPW;
               end
            end
         end

         ST_POPW: begin
            v_in       = vo_rd;
            ro_ra      = RO_AW'(vo_rd);
            di_ra      = vo_rd;
            pc_ra      = vo_rd;
            dep_acc_in = '0;
            state_in   = ST_RO0;
         end

         ST_RO0: begin
            k_in     = ro_clamped;
            dv_in    = di_rd;
            pv_in    = pc_rd;
            ro_ra    = RO_AW'(v_ff) + RO_AW'(1);
            state_in = ST_RO1;
         end

         ST_RO1: begin
            hi_in    = ro_clamped;
            state_in = ST_EDGE;
         end

         ST_EDGE: begin
            if (k_ff >= hi_ff) begin
               if (!back_ff) begin
                  head_in  = head_ff + NCNT_W'(1);
                  state_in = ST_POP;
               end else begin
                  state_in = ST_BEND;
               end
            end else begin
               et_ra    = k_ff[EDGE_W-1:0];
               state_in = ST_EW;
            end
         end

         ST_EW: begin
            w_in = et_rd;
            if (NCNT_W'(et_rd) >= v_use) begin
               // target outside the graph
               k_in     = k_ff + ECNT_W'(1);
               state_in = ST_EDGE;
            end else begin
               di_ra    = et_rd;
               pc_ra    = et_rd;
               dp_ra    = et_rd;
               state_in = back_ff ? ST_BCHK : ST_FUPD;
            end
         end

         ST_FUPD: begin
            if (newly) begin
               di_we  = 1'b1; di_wa = w_ff; di_wd = dv1;
               vo_we  = 1'b1; vo_wa = len_ff[NODE_W-1:0]; vo_wd = w_ff;
               len_in = len_ff + NCNT_W'(1);
            end
            if (dw_eff == dv1) begin
               pc_we = 1'b1; pc_wa = w_ff; pc_wd = sat_add40(pc_rd, pv_ff);
            end
            k_in     = k_ff + ECNT_W'(1);
            state_in = ST_EDGE;
         end

         ST_BCHK: begin
            if ((di_rd != dv1) || (pc_rd == '0)) begin
               k_in     = k_ff + ECNT_W'(1);
               state_in = ST_EDGE;
            end else begin
               div_start = 1'b1;
               depw_in   = dp_rd;
               state_in  = ST_BDIV;
            end
         end

         ST_BDIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = ST_BMUL;
            end
         end

         ST_BMUL: begin
            if (mul_done) begin
               dep_acc_in = sat_add48(dep_acc_ff, mul_p);
               k_in       = k_ff + ECNT_W'(1);
               state_in   = ST_EDGE;
            end
         end

         ST_BEND: begin
            dp_we    = 1'b1; dp_wa = v_ff; dp_wd = dep_acc_ff;
            ce_ra    = v_ff;
            state_in = ST_BCENT;
         end

         ST_BCENT: begin
            // the source never scores itself
            if (v_ff != src_ff) begin
               ce_we = 1'b1; ce_wa = v_ff; ce_wd = sat_add48(ce_rd, dep_acc_ff);
            end
            head_in  = head_ff - NCNT_W'(1);
            state_in = ST_POP;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CCLR;
         cnt_ff        <= '0;
         node_count_ff <= NCNT_W'(1);
         edge_count_ff <= '0;
         len_ff        <= '0;
         head_ff       <= '0;
         back_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         node_count_ff <= node_count_in;
         edge_count_ff <= edge_count_in;
         len_ff        <= len_in;
         head_ff       <= head_in;
         back_ff       <= back_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      src_ff       <= src_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      dv_ff        <= dv_in;
      pv_ff        <= pv_in;
      k_ff         <= k_in;
      hi_ff        <= hi_in;
      depw_ff      <= depw_in;
      dep_acc_ff   <= dep_acc_in;
      rd_node_ff   <= rd_node_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_node  = rsp_node_ff;
   assign rsp_score = rsp_score_ff;

   // ---------------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------------
   bce_ram #(.WIDTH(VALUE_W), .DEPTH(RO_DEPTH)) u_row_offsets (
      .clock, .wr_en(ro_we), .wr_addr(ro_wa), .wr_data(ro_wd),
      .rd_addr(ro_ra), .rd_data(ro_rd));

   bce_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_targets (
      .clock, .wr_en(et_we), .wr_addr(et_wa), .wr_data(et_wd),
      .rd_addr(et_ra), .rd_data(et_rd));

   bce_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_visit_order (
      .clock, .wr_en(vo_we), .wr_addr(vo_wa), .wr_data(vo_wd),
      .rd_addr(vo_ra), .rd_data(vo_rd));

   bce_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_distance (
      .clock, .wr_en(di_we), .wr_addr(di_wa), .wr_data(di_wd),
      .rd_addr(di_ra), .rd_data(di_rd));

   bce_ram #(.WIDTH(PC_W), .DEPTH(MAX_NODES)) u_path_count (
      .clock, .wr_en(pc_we), .wr_addr(pc_wa), .wr_data(pc_wd),
      .rd_addr(pc_ra), .rd_data(pc_rd));

   bce_ram #(.WIDTH(FIX_W), .DEPTH(MAX_NODES)) u_dependency (
      .clock, .wr_en(dp_we), .wr_addr(dp_wa), .wr_data(dp_wd),
      .rd_addr(dp_ra), .rd_data(dp_rd));

   bce_ram #(.WIDTH(FIX_W), .DEPTH(MAX_NODES)) u_centrality (
      .clock, .wr_en(ce_we), .wr_addr(ce_wa), .wr_data(ce_wd),
      .rd_addr(ce_ra), .rd_data(ce_rd));

   // ---------------------------------------------------------------------
   // ratio = (pc[v] << FRAC) / pc[w], then ratio * (1 + dep[w])
   // ---------------------------------------------------------------------
   bce_div u_div (
      .clock, .reset,
      .start(div_start),
      .dividend({pv_ff, {FRAC_BITS{1'b0}}}),
      .divisor(pc_rd),
      .done(div_done),
      .ratio(div_ratio));

   bce_mul u_mul (
      .clock, .reset,
      .start(mul_start),
      .op_a(div_ratio),
      .op_b(mul_b),
      .done(mul_done),
      .product(mul_p));

endmodule

[hw/rtl/bce_ram.sv]
// ----------------------------------------------------------------------------
// bce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/bce_div.sv]
// ----------------------------------------------------------------------------
// bce_div
// Restoring divider, one quotient bit per cycle; ratio saturates to 48 bits.
// ----------------------------------------------------------------------------
module bce_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bce_pkg::DIV_W-1:0]    dividend,
   input  logic [bce_pkg::PC_W-1:0]     divisor,
   output logic                         done,
   output logic [bce_pkg::FIX_W-1:0]    ratio
);
   import bce_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PC_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [PC_W-1:0]  dsr_ff, dsr_in;
   logic [PC_W:0]    shifted;
   logic             fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff[PC_W-1:0], quo_ff[DIV_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? shifted - {1'b0, dsr_ff} : shifted;
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done  = done_ff;
   assign ratio = (|quo_ff[DIV_W-1:FIX_W]) ? {FIX_W{1'b1}} : quo_ff[FIX_W-1:0];
endmodule

[hw/rtl/bce_mul.sv]
// ----------------------------------------------------------------------------
// bce_mul
// Shift-add fixed point multiplier, one multiplier bit per cycle.
// Result is the product shifted down by the fraction width, saturated.
// ----------------------------------------------------------------------------
module bce_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bce_pkg::FIX_W-1:0]   op_a,
   input  logic [bce_pkg::MULB_W-1:0]  op_b,
   output logic                        done,
   output logic [bce_pkg::FIX_W-1:0]   product
);
   import bce_pkg::*;

   localparam int CNT_W  = $clog2(MULB_W);
   localparam int PROD_W = 2 * MULB_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MULB_W-1:0] hi_ff, hi_in;
   logic [MULB_W-1:0] lo_ff, lo_in;
   logic [FIX_W-1:0]  a_ff, a_in;
   logic [MULB_W:0]   sum;
   logic [PROD_W-1:0] full;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? (MULB_W+1)'(a_ff) : '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         hi_in   = '0;
         lo_in   = op_b;
         a_in    = op_a;
      end else if (busy_ff) begin
         hi_in  = sum[MULB_W:1];
         lo_in  = {sum[0], lo_ff[MULB_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MULB_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
   end

   assign full    = {hi_ff, lo_ff};
   assign done    = done_ff;
   assign product = (|full[PROD_W-1:FIX_W+FRAC_BITS]) ? {FIX_W{1'b1}}
                                                       : full[FIX_W+FRAC_BITS-1:FRAC_BITS];
endmodule

[hw/rtl/bce_checker.sv]
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks for the betweenness centrality engine, bound to the top.
// ----------------------------------------------------------------------------
module bce_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [bce_pkg::MODE_W-1:0]    req_mode,
   input logic [bce_pkg::INDEX_W-1:0]   req_index,
   input logic [bce_pkg::VALUE_W-1:0]   req_value,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bce_pkg::NODE_W-1:0]    rsp_node,
   input logic [bce_pkg::SCORE_W-1:0]   rsp_score,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [bce_pkg::CSR_AW-1:0]    csr_paddr,
   input logic [bce_pkg::CSR_DW-1:0]    csr_pwdata,
   input logic [bce_pkg::CSR_DW-1:0]    csr_prdata,
   input logic                          csr_pready
);
   import bce_pkg::*;

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node) && $stable(rsp_score))
      else $error("response beat changed while stalled");

   // no response right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an offset load never produces a beat
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_WR_OFFSET && !rsp_valid |=> !rsp_valid)
      else $error("offset load produced a response");

   // clearing scores blocks the input for the sweep
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_CLEAR |=> !req_ready)
      else $error("input accepted during score clear");

endmodule

bind betweenness_centrality_engine_core bce_checker u_bce_checker (.*);

[dv/bce_checker.sv]
// ----------------------------------------------------------------------------
// bce_scoreboard
// Watches the request, response and CSR ports of the centrality engine. It
// keeps its own copy of the graph and the scores, predicts each score read
// and compares every response beat against the oldest prediction.
// ----------------------------------------------------------------------------
module bce_scoreboard
   import bce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [INDEX_W-1:0]   req_index,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [NODE_W-1:0]    rsp_node,
   input  logic [SCORE_W-1:0]   rsp_score,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   input  logic                 csr_pready,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [NODE_W-1:0]  node;
      logic [SCORE_W-1:0] score;
   } score_beat_type;

   score_beat_type      score_q[$];
   logic [NCNT_W-1:0]   node_reg;
   logic [ECNT_W-1:0]   edge_reg;
   logic [VALUE_W-1:0]  row_start[0:MAX_NODES];
   logic [NODE_W-1:0]   edge_dst[0:MAX_EDGES-1];
   logic [FIX_W-1:0]    score_mem[0:MAX_NODES-1];
   logic [PC_W-1:0]     paths[0:MAX_NODES-1];
   logic [FIX_W-1:0]    depend[0:MAX_NODES-1];
   int                  level[0:MAX_NODES-1];
   int                  visit[0:MAX_NODES-1];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int nodes_used();
      return (node_reg > MAX_NODES) ? MAX_NODES : int'(node_reg);
   endfunction

   function automatic int edges_used();
      return (edge_reg > MAX_EDGES) ? MAX_EDGES : int'(edge_reg);
   endfunction

   function automatic logic [FIX_W-1:0] add_sat(input logic [FIX_W-1:0] a,
                                                 input logic [FIX_W-1:0] b);
      logic [FIX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FIX_W] ? {FIX_W{1'b1}} : s[FIX_W-1:0];
   endfunction

   // (a * b) >> FRAC_BITS, saturating
   function automatic logic [FIX_W-1:0] fix_mul(input logic [FIX_W-1:0] a,
                                                 input logic [MULB_W-1:0] b);
      logic [FIX_W+MULB_W-1:0] p;
      logic [FIX_W+MULB_W-1:0] r;
      p = a * b;
      r = p >> FRAC_BITS;
      return (|(r >> FIX_W)) ? {FIX_W{1'b1}} : r[FIX_W-1:0];
   endfunction

   function automatic void edge_span(input int v, input int en, output int lo,
                                     output int hi);
      lo = (int'(row_start[v]) > en) ? en : int'(row_start[v]);
      hi = (int'(row_start[v+1]) > en) ? en : int'(row_start[v+1]);
   endfunction

   function automatic void brandes_pass(input int src);
      int vn, en, head, len, v, w, lo, hi, i, k;
      logic [PC_W:0]     psum;
      logic [DIV_W-1:0]  quo;
      logic [FIX_W-1:0]  ratio;
      vn = nodes_used();
      en = edges_used();
      if (src >= vn) return;
      for (i = 0; i < vn; i++) begin
         level[i]  = -1;
         paths[i]  = '0;
         depend[i] = '0;
      end
      level[src] = 0;
      paths[src] = PC_W'(1);
      visit[0]   = src;
      len  = 1;
      head = 0;
      // forward BFS, counting shortest paths
      while (head < len) begin
         v = visit[head];
         head++;
         edge_span(v, en, lo, hi);
         for (k = lo; k < hi; k++) begin
            w = int'(edge_dst[k]);
            if (w >= vn) continue;
            if (level[w] < 0 && len < MAX_NODES) begin
               level[w]   = level[v] + 1;
               visit[len] = w;
               len++;
            end
            if (level[w] == level[v] + 1) begin
               psum = {1'b0, paths[w]} + {1'b0, paths[v]};
               paths[w] = psum[PC_W] ? {PC_W{1'b1}} : psum[PC_W-1:0];
            end
         end
      end
      // backward dependency accumulation
      for (i = len - 1; i >= 0; i--) begin
         v = visit[i];
         edge_span(v, en, lo, hi);
         for (k = lo; k < hi; k++) begin
            w = int'(edge_dst[k]);
            if (w >= vn || level[w] != level[v] + 1 || paths[w] == 0) continue;
            quo   = {paths[v], {FRAC_BITS{1'b0}}} / DIV_W'(paths[w]);
            ratio = (|(quo >> FIX_W)) ? {FIX_W{1'b1}} : quo[FIX_W-1:0];
            depend[v] = add_sat(depend[v],
               fix_mul(ratio, MULB_W'(depend[w]) + (MULB_W'(1) << FRAC_BITS)));
         end
         if (v != src) score_mem[v] = add_sat(score_mem[v], depend[v]);
      end
   endfunction

   always @(posedge clock) begin
      score_beat_type got;
      score_beat_type want;
      if (reset) begin
         node_reg = NCNT_W'(1);
         edge_reg = '0;
         foreach (score_mem[i]) score_mem[i] = '0;
         score_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[2]))
               REG_NODE_COUNT: node_reg = csr_pwdata[NCNT_W-1:0];
               REG_EDGE_COUNT: edge_reg = csr_pwdata[ECNT_W-1:0];
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_mode)
               MODE_WR_OFFSET:
                  if (req_index <= MAX_NODES) row_start[req_index] = req_value;
               MODE_WR_EDGE:
                  if (req_index < MAX_EDGES && req_value < MAX_NODES)
                     edge_dst[req_index] = req_value[NODE_W-1:0];
               MODE_RUN:
                  brandes_pass(int'(req_index));
               MODE_READ:
                  if (req_index < nodes_used()) begin
                     want.node  = req_index[NODE_W-1:0];
                     want.score = score_mem[req_index];
                     score_q.insert(score_q.size(), want);
                  end
               MODE_CLEAR:
                  foreach (score_mem[i]) score_mem[i] = '0;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (score_q.size() == 0) begin
               report($sformatf("unexpected beat node %0d score %h", rsp_node, rsp_score));
            end else begin
               got = score_q.pop_front();
               if (rsp_node !== got.node)
                  report($sformatf("node %0d, want %0d", rsp_node, got.node));
               if (rsp_score !== got.score)
                  report($sformatf("node %0d score %h, want %h",
                                   got.node, rsp_score, got.score));
            end
         end
      end
      pending = score_q.size();
   end

endmodule

[dv/tb_betweenness_centrality_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_betweenness_centrality_engine_core
// Loads small CSR graphs, runs sources, reads and clears scores through the
// request channel with random gaps and response stalls; the checker predicts
// and compares every score beat. Only the opening CSR writes meet a busy engine.
// ----------------------------------------------------------------------------
module tb_betweenness_centrality_engine_core
   import bce_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // modes the engine ignores
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
   localparam int TOTAL_BEATS = 1450;
   localparam int CALM_AFTER  = 1300;   // no idling past this many beats
   localparam int SETTLE      = 1100;   // covers a full clear sweep

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode;
   logic [INDEX_W-1:0]   req_index;
   logic [VALUE_W-1:0]   req_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [NODE_W-1:0]    rsp_node;
   logic [SCORE_W-1:0]   rsp_score;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [CSR_AW-1:0]    csr_paddr;
   logic [CSR_DW-1:0]    csr_pwdata;
   logic [CSR_DW-1:0]    csr_prdata;
   logic                 csr_pready;

   int  fail_count;
   int  pending;
   int  beats_sent;
   bit  quiet;        // phase with no idling at all
   bit  hold_rsp;     // request for one long response stall
   int  nodes_live;   // clamped node count as programmed
   int  edges_loaded; // edge slots 0..edges_loaded-1 hold known targets

   betweenness_centrality_engine_core dut (.*);

   bce_scoreboard chk (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_index, .req_value,
      .rsp_valid, .rsp_ready, .rsp_node, .rsp_score,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic bit idle_off();
      return quiet || beats_sent >= CALM_AFTER;
   endfunction

   // One request beat; valid stays up after acceptance so back-to-back beats
   // need no extra assignment.
   task automatic send_beat(input logic [MODE_W-1:0] m, input int idx, input int val);
      if (!idle_off() && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= m;
      req_index <= INDEX_W'(idx);
      req_value <= VALUE_W'(val);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // APB write: setup then access; pready is tied high
   task automatic csr_write(input reg_index_type r, input int data);
      req_valid   <= 1'b0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= CSR_DW'(data);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_sizes(input int v, input int e);
      csr_write(REG_NODE_COUNT, v);
      csr_write(REG_EDGE_COUNT, e);
      nodes_live = (v > MAX_NODES) ? MAX_NODES : v;
   endtask

   // Wait for every score beat; a trailing read flushes runs still in flight.
   task automatic drain();
      if (nodes_live > 0) send_beat(MODE_READ, 0, 0);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Offsets 0..v and edge slots 0..slots-1, so a run never touches an
   // unwritten entry. Offsets mostly ascend, now and then out of order.
   task automatic load_graph(input int v, input int slots);
      int acc, off, i;
      acc = 0;
      for (i = 0; i <= v; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            off = $urandom_range(0, slots);
         end else begin
            acc = acc + $urandom_range(0, 3);
            if (acc > slots) acc = slots;
            off = acc;
         end
         send_beat(MODE_WR_OFFSET, i, off);
      end
      for (i = 0; i < slots; i++)
         send_beat(MODE_WR_EDGE, i, ($urandom_range(0, 6) == 0 && v < MAX_NODES) ?
                   $urandom_range(v, MAX_NODES - 1) : $urandom_range(0, v - 1));
      if (slots > edges_loaded) edges_loaded = slots;
   endtask

   // Random beat for a phase whose graph is fully loaded.
   task automatic random_beat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         send_beat(MODE_RUN, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
                   $urandom_range(0, nodes_live + 1), $urandom_range(0, 16383));
      else if (pick < 52)
         send_beat(MODE_READ, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
                   $urandom_range(0, nodes_live - 1), $urandom_range(0, 16383));
      else if (pick < 68) begin
         if ($urandom_range(0, 4) == 0)
            send_beat(MODE_WR_OFFSET, $urandom_range(MAX_NODES + 1, 8191),
                      $urandom_range(0, 16383));
         else
            send_beat(MODE_WR_OFFSET, $urandom_range(0, nodes_live),
                      $urandom_range(0, edges_loaded));
      end else if (pick < 88) begin
         // targets of 1024 and up are dropped, leaving the slot as it was
         if (edges_loaded > 0 && $urandom_range(0, 3) != 0)
            send_beat(MODE_WR_EDGE, $urandom_range(0, edges_loaded - 1),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_NODES, 16383) :
                      $urandom_range(0, nodes_live + 2));
         else
            send_beat(MODE_WR_EDGE, $urandom_range(0, 8191),
                      $urandom_range(MAX_NODES, 16383));
      end else if (pick < 91)
         send_beat(MODE_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 16383));
      else
         send_beat(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                   $urandom_range(0, 8191), $urandom_range(0, 16383));
   endtask

   // Response side: random stall bursts, plus one long hold on request.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (2500) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!idle_off() && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int v, slots, e, i;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_mode    <= MODE_READ;
      req_index   <= '0;
      req_value   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      beats_sent   = 0;
      quiet        = 1'b0;
      hold_rsp     = 1'b0;
      edges_loaded = 0;
      nodes_live   = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: a six-node graph with the edge count at its top (clamped)
      set_sizes(6, 16383);
      load_graph(6, 10);
      for (i = 0; i < 6; i++) send_beat(MODE_RUN, i, 0);
      send_beat(MODE_RUN, 6, 0);                    // source outside the graph
      send_beat(MODE_RUN, 8191, 16383);
      for (i = 0; i < 6; i++) send_beat(MODE_READ, i, 0);
      send_beat(MODE_READ, 8191, 0);                // read outside the graph
      send_beat(MODE_WR_OFFSET, 8191, 16383);       // offset slot out of range
      send_beat(MODE_WR_EDGE, 0, 16383);            // target too large, dropped
      for (i = MODE_SPARE_FIRST; i <= MODE_SPARE_LAST; i++)
         send_beat(MODE_W'(i), 8191, 16383);
      send_beat(MODE_RUN, 0, 0);
      send_beat(MODE_READ, 1, 0);
      send_beat(MODE_CLEAR, 0, 0);
      send_beat(MODE_READ, 1, 0);

      // Long receiver hold while reads keep coming: the engine must back up
      hold_rsp = 1'b1;
      quiet    = 1'b1;
      for (i = 0; i < 40; i++) send_beat(MODE_READ, $urandom_range(0, 5), 0);
      quiet = 1'b0;
      drain();

      // Zero nodes: runs and reads do nothing
      set_sizes(0, 0);
      send_beat(MODE_RUN, 0, 0);
      send_beat(MODE_READ, 0, 0);
      send_beat(MODE_CLEAR, 0, 0);
      drain();

      // Top node counts: reads, clears and an out-of-range run; graph memory is not loaded
      set_sizes(2047, 0);
      send_beat(MODE_READ, MAX_NODES - 1, 0);
      for (i = 0; i < 12; i++) send_beat(MODE_READ, $urandom_range(0, 8191), 0);
      send_beat(MODE_RUN, 8191, 0);
      drain();
      set_sizes(MAX_NODES, MAX_EDGES);
      send_beat(MODE_CLEAR, 0, 0);
      for (i = 0; i < 10; i++) send_beat(MODE_READ, $urandom_range(0, 1023), 0);
      drain();

      // Random phases on small graphs
      while (beats_sent < TOTAL_BEATS) begin
         v     = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
         slots = $urandom_range(0, 3 * v);
         case ($urandom_range(0, 3))
            0:       e = 0;
            1:       e = 16383;
            2:       e = $urandom_range(0, slots);
            default: e = slots;
         endcase
         set_sizes(v, e);
         quiet = ($urandom_range(0, 3) == 0);
         load_graph(v, slots);
         repeat ($urandom_range(60, 140)) begin
            if (beats_sent < TOTAL_BEATS) random_beat();
         end
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #600_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
